>>> hdl/assert_macros.svh
// Assertion macros shared by the timer deadline queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while the active-low reset is held.
`define TDQ_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdq assertion failed");

// Concurrent check that a condition never holds outside reset.
`define TDQ_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tdq forbidden condition seen");

`endif

>>> hdl/tdq_pkg.sv
// Shared types and constants of the timer deadline queue.
// No dependencies; imported by every module of the block but tdq_ram.
package tdq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int TIME_BITS_DEF = 48;
    localparam int MAX_RESULTS   = 64;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int HANDLE_W      = 32;
    localparam int DELAY_W       = 32;
    localparam int NEW_TIME_W    = 48;
    localparam int ELAPSED_W     = 48;
    localparam int SEQ_W         = 16;
    localparam int MODE_W        = 2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_UPDATE,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [HANDLE_W-1:0]   cb;
        logic [HANDLE_W-1:0]   arg;
        logic [DELAY_W-1:0]    delay;
        logic [NEW_TIME_W-1:0] new_time;
    } t_cmd;

    // Command handoff from the front queue to the execution engine.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_if;

endpackage

>>> hdl/timer_deadline_queue_core.sv
// Top level of the timer deadline queue.
// Depends on tdq_pkg, tdq_front and tdq_back (which uses tdq_ram).
//
// Usage: a store of pending timed callbacks, one command per input beat.
// Input channel (i_in_valid / o_in_stall): i_mode selects add, update or clear.
// Add stores both handles with creation time and a saturated wake time in the
// lowest free slot; update loads a new current time and releases expired
// entries earliest wake first, oldest add first on a tie; clear drops all.
// Output channel (o_out_valid / i_out_stall): each command yields one or more
// beats, the final one marked with o_last. An update releases at most 64
// entries; the rest wait for a later update.
// Scanning: an add walks the occupied slots ahead of the free one in order. An
// update runs one scan of the entry memory per release, reading one entry at a
// time through the single read port of that memory, plus one closing scan.
// A two-beat command queue keeps accepting, until it is full, while the engine or a
// stalled receiver holds things up; a stalled output beat holds until taken.
// Reset empties the store, zeroes the time and the add sequence, and needs
// no clearing pass since valid bits live in flip-flops.
module timer_deadline_queue_core import tdq_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [HANDLE_W-1:0]   i_callback_handle,
    input  logic [HANDLE_W-1:0]   i_argument_handle,
    input  logic [DELAY_W-1:0]    i_delay_ticks,
    input  logic [NEW_TIME_W-1:0] i_new_time,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_fired,
    output logic [HANDLE_W-1:0]   o_out_callback,
    output logic [HANDLE_W-1:0]   o_out_argument,
    output logic [ELAPSED_W-1:0]  o_elapsed_ticks,
    output logic                  o_status,
    output logic                  o_last
);

    // Decoded commands travel from the front queue to the engine.
    t_cmd_if w_cmd;
    logic    w_pop;

    tdq_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_callback_handle (i_callback_handle),
        .i_argument_handle (i_argument_handle),
        .i_delay_ticks     (i_delay_ticks),
        .i_new_time        (i_new_time),
        .o_cmd             (w_cmd),
        .i_pop             (w_pop)
    );

    // The engine owns the entry memory and the registered output beat.
    tdq_back #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fired         (o_fired),
        .o_out_callback  (o_out_callback),
        .o_out_argument  (o_out_argument),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

>>> hdl/tdq_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tdq_front.sv
// Front end: accepts input beats, decodes the mode and queues commands.
// Depends on tdq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tdq_front import tdq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [HANDLE_W-1:0]   i_callback_handle,
    input  logic [HANDLE_W-1:0]   i_argument_handle,
    input  logic [DELAY_W-1:0]    i_delay_ticks,
    input  logic [NEW_TIME_W-1:0] i_new_time,
    output t_cmd_if               o_cmd,
    input  logic                  i_pop
);

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.cb       = i_callback_handle;
        w_cmd.arg      = i_argument_handle;
        w_cmd.delay    = i_delay_ticks;
        w_cmd.new_time = i_new_time;
        case (i_mode)
            MODE_ADD:    w_cmd.op = OP_ADD;
            MODE_UPDATE: w_cmd.op = OP_UPDATE;
            MODE_CLEAR:  w_cmd.op = OP_CLEAR;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'(QD));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `TDQ_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > 2'(QD))
    `TDQ_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_cnt == 2'd0))

endmodule

>>> hdl/tdq_back.sv
// Execution engine: entry store, expiry scan, release ordering and output register.
// Depends on tdq_pkg, tdq_ram and assert_macros.svh.
`include "assert_macros.svh"
module tdq_back import tdq_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd_if              i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_fired,
    output logic [HANDLE_W-1:0]  o_out_callback,
    output logic [HANDLE_W-1:0]  o_out_argument,
    output logic [ELAPSED_W-1:0] o_elapsed_ticks,
    output logic                 o_status,
    output logic                 o_last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = 2 * HANDLE_W + 2 * TIME_BITS + SEQ_W;
    localparam int SUM_W = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam int O_WAKE = SEQ_W;
    localparam int O_CRT  = SEQ_W + TIME_BITS;
    localparam int O_ARG  = SEQ_W + 2 * TIME_BITS;
    localparam int O_CB   = SEQ_W + 2 * TIME_BITS + HANDLE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_FLUSH,
        ST_RESP
    } t_state;

    t_state               r_st;
    logic [CAPACITY-1:0]  r_valid;
    logic [TIME_BITS-1:0] r_time;
    logic [SEQ_W-1:0]     r_seq;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_chk;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_status;
    t_cmd                 r_cmd;

    logic                 r_best_vld;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TIME_BITS-1:0] r_best_wake;
    logic [SEQ_W-1:0]     r_best_age;
    logic [HANDLE_W-1:0]  r_best_cb;
    logic [HANDLE_W-1:0]  r_best_arg;
    logic [TIME_BITS-1:0] r_best_crt;

    logic                 r_have;
    logic [HANDLE_W-1:0]  r_h_cb;
    logic [HANDLE_W-1:0]  r_h_arg;
    logic [TIME_BITS-1:0] r_h_crt;

    logic                 r_o_valid;
    logic                 r_o_fired;
    logic [HANDLE_W-1:0]  r_o_cb;
    logic [HANDLE_W-1:0]  r_o_arg;
    logic [ELAPSED_W-1:0] r_o_elapsed;
    logic                 r_o_status;
    logic                 r_o_last;

    logic                 w_we;
    logic [ENT_W-1:0]     w_wdata;
    logic [ENT_W-1:0]     w_rdata;
    logic [SUM_W-1:0]     w_sum;
    logic [TIME_BITS-1:0] w_wake;
    logic [TIME_BITS-1:0] w_rd_wake;
    logic [SEQ_W-1:0]     w_age;
    logic                 w_cand;
    logic                 w_better;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_out_free;

    tdq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Saturating wake time for an add.
    assign w_sum  = SUM_W'(r_time) + SUM_W'(r_cmd.delay);
    assign w_wake = (w_sum > SUM_W'(TMAX)) ? TMAX : TIME_BITS'(w_sum);
    assign w_wdata = {r_cmd.cb, r_cmd.arg, r_time, w_wake, r_seq};
    assign w_we = (r_st == ST_FIND) && !r_valid[r_idx];

    // One stored entry is compared per cycle against the running best.
    assign w_rd_wake = w_rdata[O_WAKE +: TIME_BITS];
    assign w_age     = r_seq - w_rdata[SEQ_W-1:0];
    assign w_cand    = r_chk && r_valid[r_chk_idx] && (w_rd_wake <= r_time);
    assign w_better  = !r_best_vld || (w_rd_wake < r_best_wake) ||
                       ((w_rd_wake == r_best_wake) && (w_age > r_best_age));

    assign w_elapsed  = (r_time >= r_h_crt) ? (r_time - r_h_crt) : '0;
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign o_pop      = (r_st == ST_IDLE) && i_cmd.valid;

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_cmd.valid) begin
            r_cmd <= i_cmd.cmd;
        end
        if (w_cand && w_better) begin
            r_best_idx  <= r_chk_idx;
            r_best_wake <= w_rd_wake;
            r_best_age  <= w_age;
            r_best_cb   <= w_rdata[O_CB +: HANDLE_W];
            r_best_arg  <= w_rdata[O_ARG +: HANDLE_W];
            r_best_crt  <= w_rdata[O_CRT +: TIME_BITS];
        end
        r_chk_idx <= r_idx;

        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_valid    <= '0;
            r_time     <= '0;
            r_seq      <= '0;
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_cnt      <= '0;
            r_status   <= 1'b0;
            r_best_vld <= 1'b0;
            r_have     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_chk <= (r_st == ST_SCAN);
            if (w_cand && w_better) begin
                r_best_vld <= 1'b1;
            end
            if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_st)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        r_idx      <= '0;
                        r_status   <= 1'b0;
                        r_cnt      <= '0;
                        r_have     <= 1'b0;
                        r_best_vld <= 1'b0;
                        case (i_cmd.cmd.op)
                            OP_ADD:    r_st <= ST_FIND;
                            OP_UPDATE: begin
                                r_time <= TIME_BITS'(i_cmd.cmd.new_time);
                                r_st   <= ST_SCAN;
                            end
                            OP_CLEAR: begin
                                r_valid <= '0;
                                r_st    <= ST_RESP;
                            end
                            default:   r_st <= ST_RESP;
                        endcase
                    end
                end
                ST_FIND: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        r_seq          <= r_seq + 1'b1;
                        r_st           <= ST_RESP;
                    end else if (r_idx == IDX_W'(CAPACITY - 1)) begin
                        r_status <= 1'b1;
                        r_st     <= ST_RESP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_idx == IDX_W'(CAPACITY - 1)) begin
                        r_st <= ST_SCAN_END;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SCAN_END: begin
                    r_st <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (r_best_vld) begin
                        if (!r_have || w_out_free) begin
                            if (r_have) begin
                                r_o_valid   <= 1'b1;
                                r_o_fired   <= 1'b1;
                                r_o_cb      <= r_h_cb;
                                r_o_arg     <= r_h_arg;
                                r_o_elapsed <= ELAPSED_W'(w_elapsed);
                                r_o_status  <= 1'b0;
                                r_o_last    <= 1'b0;
                            end
                            r_have              <= 1'b1;
                            r_h_cb              <= r_best_cb;
                            r_h_arg             <= r_best_arg;
                            r_h_crt             <= r_best_crt;
                            r_valid[r_best_idx] <= 1'b0;
                            r_cnt               <= r_cnt + 1'b1;
                            r_best_vld          <= 1'b0;
                            r_idx               <= '0;
                            if (r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                                r_st <= ST_FLUSH;
                            end else begin
                                r_st <= ST_SCAN;
                            end
                        end
                    end else if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_fired   <= r_have;
                        r_o_cb      <= r_have ? r_h_cb : '0;
                        r_o_arg     <= r_have ? r_h_arg : '0;
                        r_o_elapsed <= r_have ? ELAPSED_W'(w_elapsed) : '0;
                        r_o_status  <= 1'b0;
                        r_o_last    <= 1'b1;
                        r_have      <= 1'b0;
                        r_st        <= ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_fired   <= 1'b1;
                        r_o_cb      <= r_h_cb;
                        r_o_arg     <= r_h_arg;
                        r_o_elapsed <= ELAPSED_W'(w_elapsed);
                        r_o_status  <= 1'b0;
                        r_o_last    <= 1'b1;
                        r_have      <= 1'b0;
                        r_st        <= ST_IDLE;
                    end
                end
                ST_RESP: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_fired   <= 1'b0;
                        r_o_cb      <= '0;
                        r_o_arg     <= '0;
                        r_o_elapsed <= '0;
                        r_o_status  <= r_status;
                        r_o_last    <= 1'b1;
                        r_st        <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_fired         = r_o_fired;
    assign o_out_callback  = r_o_cb;
    assign o_out_argument  = r_o_arg;
    assign o_elapsed_ticks = r_o_elapsed;
    assign o_status        = r_o_status;
    assign o_last          = r_o_last;

    `TDQ_NEVER(a_cnt_limit, i_clk, i_rst_n, r_cnt > CNT_W'(MAX_RESULTS))
    `TDQ_NEVER(a_idle_no_held, i_clk, i_rst_n, (r_st == ST_IDLE) && r_have)
    `TDQ_ASSERT(a_flush_full, i_clk, i_rst_n,
        (r_st == ST_FLUSH) |-> (r_have && (r_cnt == CNT_W'(MAX_RESULTS))))

endmodule

>>> tb/timer_deadline_queue_core_tb.sv
// Self-checking testbench for timer_deadline_queue_core: add, update, clear and
// unused commands checked beat by beat against a predictor held in this file.
// Depends on tdq_pkg and the timer_deadline_queue_core RTL.
module timer_deadline_queue_core_tb;
    import tdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                  SLOTS      = CAPACITY_DEF;
    localparam logic [47:0]         TIME_MAX   = {48{1'b1}};
    localparam int                  STALL_LIMIT = 30000;
    localparam int                  LONG_HOLD  = 1500;

    // One output beat as the block should present it.
    typedef struct {
        logic        fired;
        logic [31:0] cb;
        logic [31:0] arg;
        logic [47:0] elapsed;
        logic        status;
        logic        last;
    } t_release;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode;
    logic [HANDLE_W-1:0]   i_callback_handle;
    logic [HANDLE_W-1:0]   i_argument_handle;
    logic [DELAY_W-1:0]    i_delay_ticks;
    logic [NEW_TIME_W-1:0] i_new_time;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_fired;
    logic [HANDLE_W-1:0]   o_out_callback;
    logic [HANDLE_W-1:0]   o_out_argument;
    logic [ELAPSED_W-1:0]  o_elapsed_ticks;
    logic                  o_status;
    logic                  o_last;

    timer_deadline_queue_core u_dut (.*);

    // Shadow copy of the timer store, updated when an input beat is taken.
    logic [31:0] shadow_cb      [SLOTS];
    logic [31:0] shadow_arg     [SLOTS];
    logic [47:0] shadow_created [SLOTS];
    logic [47:0] shadow_wake    [SLOTS];
    logic [15:0] shadow_order   [SLOTS];
    logic        shadow_live    [SLOTS];
    logic [47:0] shadow_now;
    logic [15:0] shadow_seq;

    // Beats still owed by the block, oldest first.
    t_release pending_releases[$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;
    int  hold_cycles    = 0;
    // Time the stimulus believes the block holds; drives update choices.
    logic [47:0] stim_now = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Every input starts known; reset is asserted only once.
    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_mode            <= OP_NOP;
        i_callback_handle <= '0;
        i_argument_handle <= '0;
        i_delay_ticks     <= '0;
        i_new_time        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_release quiet_beat(logic status);
        t_release r;
        r = '{1'b0, 32'd0, 32'd0, 48'd0, status, 1'b1};
        return r;
    endfunction

    // Predicts the beats one accepted command causes and queues them.
    task automatic predict_command(t_op op, logic [31:0] cb, logic [31:0] arg,
                                   logic [31:0] delay, logic [47:0] new_now);
        int          slot;
        int          best;
        int          released;
        logic [15:0] age;
        logic [15:0] best_age;
        logic [48:0] wake_sum;
        t_release    r;
        case (op)
            OP_ADD: begin
                slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!shadow_live[i]) slot = i;
                if (slot < 0) begin
                    pending_releases.push_back(quiet_beat(1'b1));
                end else begin
                    wake_sum = {1'b0, shadow_now} + {17'd0, delay};
                    shadow_cb[slot]      = cb;
                    shadow_arg[slot]     = arg;
                    shadow_created[slot] = shadow_now;
                    shadow_wake[slot]    = wake_sum[48] ? TIME_MAX : wake_sum[47:0];
                    shadow_order[slot]   = shadow_seq;
                    shadow_live[slot]    = 1'b1;
                    shadow_seq           = shadow_seq + 16'd1;
                    pending_releases.push_back(quiet_beat(1'b0));
                end
            end
            OP_UPDATE: begin
                shadow_now = new_now;
                released   = 0;
                while (released < MAX_RESULTS) begin
                    best     = -1;
                    best_age = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (shadow_live[i] && shadow_wake[i] <= shadow_now) begin
                            age = shadow_seq - shadow_order[i];
                            if (best < 0 || shadow_wake[i] < shadow_wake[best] ||
                                (shadow_wake[i] == shadow_wake[best] && age > best_age)) begin
                                best     = i;
                                best_age = age;
                            end
                        end
                    end
                    if (best < 0) break;
                    r.fired   = 1'b1;
                    r.cb      = shadow_cb[best];
                    r.arg     = shadow_arg[best];
                    r.elapsed = (shadow_now >= shadow_created[best]) ?
                                shadow_now - shadow_created[best] : '0;
                    r.status  = 1'b0;
                    r.last    = 1'b0;
                    pending_releases.push_back(r);
                    shadow_live[best] = 1'b0;
                    released++;
                end
                if (released == 0)
                    pending_releases.push_back(quiet_beat(1'b0));
                else
                    pending_releases[$].last = 1'b1;
            end
            OP_CLEAR: begin
                foreach (shadow_live[i]) shadow_live[i] = 1'b0;
                pending_releases.push_back(quiet_beat(1'b0));
            end
            default: pending_releases.push_back(quiet_beat(1'b0));
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, seen, want);
    endtask

    // Sends one command beat and predicts it when the block takes it. Valid is
    // left high on exit so that a following beat never toggles it in one step.
    task automatic send_command(t_op op, logic [31:0] cb, logic [31:0] arg,
                                logic [31:0] delay, logic [47:0] new_now);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= op;
        i_callback_handle <= cb;
        i_argument_handle <= arg;
        i_delay_ticks     <= delay;
        i_new_time        <= new_now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_UPDATE) stim_now = new_now;
        predict_command(op, cb, arg, delay, new_now);
    endtask

    // Lowers valid and waits until the block has delivered every owed beat.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_releases.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Result checker: every beat taken is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_releases.size() == 0) begin
                mismatch_count++;
                $display("%0t: output beat with nothing expected", $realtime);
            end else begin
                t_release want;
                want = pending_releases.pop_front();
                if (o_fired !== want.fired)
                    report_mismatch("fired", o_fired, want.fired);
                if (o_out_callback !== want.cb)
                    report_mismatch("callback", o_out_callback, want.cb);
                if (o_out_argument !== want.arg)
                    report_mismatch("argument", o_out_argument, want.arg);
                if (o_elapsed_ticks !== want.elapsed)
                    report_mismatch("elapsed", o_elapsed_ticks, want.elapsed);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // Receiver: short random stalls, or one long hold when a test asks for it.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that stops moving beats on either side is a failure.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timer_deadline_queue_core regression: fail");
            $finish;
        end
    end

    // Every mode at least once, extreme handle values, zero and largest delay, and a
    // release order where equal wake times must leave oldest first.
    task automatic test_basic_modes();
        send_command(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
        send_command(OP_UPDATE, '0, '0, '0, 48'd100);
        send_command(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'd0, '0);
        send_command(OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'd50, '0);
        send_command(OP_ADD, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'd50, '0);
        send_command(OP_ADD, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, '0);
        send_command(OP_ADD, 32'h0000_0007, 32'h0000_0009, 32'd20, '0);
        send_command(OP_UPDATE, '0, '0, '0, 48'd150);
        send_command(OP_UPDATE, '0, '0, '0, 48'd150);
        send_command(OP_CLEAR, '0, '0, '0, '0);
        send_command(OP_UPDATE, '0, '0, '0, TIME_MAX);
        wait_drained();
    endtask

    // Wake time saturation near the top of the time range.
    task automatic test_wake_saturation();
        send_command(OP_UPDATE, '0, '0, '0, TIME_MAX - 48'd10);
        send_command(OP_ADD, 32'hCAFE_0001, 32'h1, 32'hFFFF_FFFF, '0);
        send_command(OP_ADD, 32'hCAFE_0002, 32'h2, 32'd11, '0);
        send_command(OP_ADD, 32'hCAFE_0003, 32'h3, 32'd5, '0);
        send_command(OP_UPDATE, '0, '0, '0, TIME_MAX - 48'd1);
        send_command(OP_UPDATE, '0, '0, '0, TIME_MAX);
        send_command(OP_CLEAR, '0, '0, '0, '0);
        send_command(OP_UPDATE, '0, '0, '0, 48'd0);
        wait_drained();
    endtask

    // Fill the store, overflow it, then release all of it in one update.
    task automatic test_full_store();
        for (int i = 0; i < SLOTS; i++)
            send_command(OP_ADD, $urandom, $urandom, $urandom_range(0, 3), '0);
        send_command(OP_ADD, 32'hDEAD_BEEF, 32'hBEEF_DEAD, 32'd0, '0);
        send_command(OP_UPDATE, '0, '0, '0, stim_now + 48'd3);
        wait_drained();
    endtask

    // Mostly adds with short delays and updates that step time forward, with
    // some large jumps, clears and unused commands mixed in.
    task automatic test_random_traffic(int count);
        int          pick;
        logic [31:0] delay;
        logic [47:0] next_now;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0:       delay = $urandom;
                    1:       delay = 32'd0;
                    default: delay = $urandom_range(0, 200);
                endcase
                send_command(OP_ADD, $urandom, $urandom, delay, '0);
            end else if (pick < 90) begin
                case ($urandom_range(0, 19))
                    0:       next_now = 48'({$urandom, $urandom});
                    1:       next_now = stim_now - 48'($urandom_range(0, 50));
                    default: next_now = stim_now + 48'($urandom_range(0, 150));
                endcase
                send_command(OP_UPDATE, '0, '0, '0, next_now);
            end else if (pick < 95) begin
                send_command(OP_CLEAR, $urandom, $urandom, $urandom, '0);
            end else begin
                send_command(OP_NOP, $urandom, $urandom, $urandom,
                             48'({$urandom, $urandom}));
            end
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming,
    // so the command queue fills and the block stalls its input.
    task automatic test_output_hold();
        tx_idle     = 1'b0;
        hold_cycles = LONG_HOLD;
        for (int i = 0; i < 6; i++)
            send_command(OP_ADD, $urandom, $urandom, 32'd1, '0);
        send_command(OP_UPDATE, '0, '0, '0, stim_now + 48'd2);
        test_random_traffic(10);
        tx_idle = 1'b1;
        wait_drained();
    endtask

    initial begin
        foreach (shadow_live[i]) shadow_live[i] = 1'b0;
        shadow_now = '0;
        shadow_seq = '0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        test_basic_modes();
        test_wake_saturation();
        test_full_store();
        test_random_traffic(20);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(20);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_output_hold();
        test_random_traffic(20);
        wait_drained();
        // Final stretch runs with no idling on either side.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(15);
        send_command(OP_UPDATE, '0, '0, '0, TIME_MAX);
        wait_drained();
        if (mismatch_count == 0)
            $display("timer_deadline_queue_core regression: pass");
        else
            $display("timer_deadline_queue_core regression: fail");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/tdq_pkg.sv
hdl/tdq_ram.sv
hdl/tdq_front.sv
hdl/tdq_back.sv
hdl/timer_deadline_queue_core.sv
tb/timer_deadline_queue_core_tb.sv
